// ===== rtl/core/t16pc_pkg.sv =====
// Shared types, register codes and helpers for the 16-bit timer/counter.
package t16pc_pkg;

    localparam int CNT_W      = 16;
    localparam int PRE_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [PRE_W-1:0] prescale_t;

    // Waveform generation modes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_CTC_CMPA = 3'd1;
    localparam logic [2:0] MODE_CTC_CAP  = 3'd2;
    localparam logic [2:0] MODE_PWM8     = 3'd3;
    localparam logic [2:0] MODE_PWM10    = 3'd4;
    localparam logic [2:0] MODE_PWM_CAP  = 3'd5;
    localparam logic [2:0] MODE_PWM_CMPA = 3'd6;

    // Clock select codes
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;

    // Compare output modes
    localparam logic [1:0] COM_OFF    = 2'd0;
    localparam logic [1:0] COM_TOGGLE = 2'd1;
    localparam logic [1:0] COM_NONINV = 2'd2;
    localparam logic [1:0] COM_INV    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_RISING   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLES  = 3'd7;

    typedef struct packed {
        logic [2:0] wave_mode;
        logic [2:0] clock_select;
        count_t     cmp_a;
        count_t     cmp_b;
        count_t     top_reg;
        logic [3:0] output_modes;
        logic       cap_rising;
        logic [1:0] irq_en;
    } cfg_t;

    typedef struct packed {
        prescale_t pre;
        count_t    cnt;
        logic      pin_a;
        logic      pin_b;
        logic      last_pin;
        count_t    cap;
    } state_t;

    typedef struct packed {
        count_t count_now;
        logic   wave_a;
        logic   wave_b;
        logic   overflow_irq;
        logic   capture_irq;
        count_t capture_value;
    } result_t;

    // Low prescaler bits that must all be set for a timer strobe.
    function automatic prescale_t prescale_mask(input logic [2:0] cs);
        prescale_t mask;
        case (cs)
            CS_DIV1:    mask = prescale_t'(0);
            CS_DIV8:    mask = prescale_t'(7);
            CS_DIV64:   mask = prescale_t'(63);
            CS_DIV256:  mask = prescale_t'(255);
            CS_DIV1024: mask = prescale_t'(1023);
            default:    mask = prescale_t'(0);
        endcase
        return mask;
    endfunction

endpackage

// ===== rtl/core/t16pc_ifs.sv =====
// Channel interfaces: capture pin tick in, timer result out.
interface t16pc_cap_if;
    logic valid;
    logic ready;
    logic capture_pin;

    modport source (output valid, output capture_pin, input ready);
    modport sink   (input valid, input capture_pin, output ready);
endinterface

interface t16pc_res_if import t16pc_pkg::*; ();
    logic   valid;
    logic   ready;
    count_t count_now;
    logic   wave_a;
    logic   wave_b;
    logic   overflow_irq;
    logic   capture_irq;
    count_t capture_value;

    modport source (
        output valid, output count_now, output wave_a, output wave_b,
        output overflow_irq, output capture_irq, output capture_value,
        input  ready
    );
    modport sink (
        input  valid, input count_now, input wave_a, input wave_b,
        input  overflow_irq, input capture_irq, input capture_value,
        output ready
    );
endinterface

// ===== rtl/core/t16pc_step.sv =====
// One timer tick: prescaler, counter, compare outputs and input capture.
module t16pc_step import t16pc_pkg::*; (
    input  cfg_t    cfg,
    input  state_t  cur,
    input  logic    capture_pin,
    output state_t  nxt,
    output result_t res
);

    function automatic logic connected(input logic [1:0] com, input logic pwm,
                                       input logic toggle_ok);
        logic c;
        c = 1'b1;
        if (com == COM_OFF)
            c = 1'b0;
        else if (pwm && com == COM_TOGGLE && !toggle_ok)
            c = 1'b0;
        return c;
    endfunction

    function automatic logic wave_next(input logic level, input logic [1:0] com,
                                       input logic pwm, input logic conn,
                                       input logic match, input logic bottom);
        logic v;
        v = level;
        if (conn)
        begin
            if (!pwm)
            begin
                if (match)
                    v = (com == COM_TOGGLE) ? ~level : (com == COM_INV);
            end
            else if (com == COM_TOGGLE)
            begin
                if (match)
                    v = ~level;
            end
            else if (bottom)
                v = (com == COM_NONINV);
            else if (match)
                v = (com == COM_INV);
        end
        return v;
    endfunction

    logic [2:0] mode;
    logic       pwm;
    logic [1:0] com_a;
    logic [1:0] com_b;
    count_t     top;
    logic       cap_edge;
    logic       cap_ev;
    logic       running;
    prescale_t  mask;
    logic       strobe;
    logic       at_top;
    count_t     cnt_new;
    logic       bottom;
    logic       ovf;
    logic       conn_a;
    logic       conn_b;

    always_comb
    begin
        // the unused mode code runs as normal mode
        mode  = (cfg.wave_mode > MODE_PWM_CMPA) ? MODE_NORMAL : cfg.wave_mode;
        pwm   = (mode >= MODE_PWM8);
        com_a = cfg.output_modes[1:0];
        com_b = cfg.output_modes[3:2];

        case (mode)
            MODE_CTC_CMPA, MODE_PWM_CMPA: top = cfg.cmp_a;
            MODE_CTC_CAP, MODE_PWM_CAP:   top = cfg.top_reg;
            MODE_PWM8:                    top = count_t'(8'hFF);
            MODE_PWM10:                   top = count_t'(10'h3FF);
            default:                      top = '1;
        endcase

        cap_edge = cfg.cap_rising ? (capture_pin & ~cur.last_pin)
                                  : (~capture_pin & cur.last_pin);
        cap_ev   = cap_edge && !(mode inside {MODE_CTC_CAP, MODE_PWM_CAP});

        running = cfg.clock_select inside {[CS_DIV1:CS_DIV1024]};
        mask    = prescale_mask(cfg.clock_select);
        strobe  = running && ((cur.pre & mask) == mask);

        at_top  = (cur.cnt == top);
        cnt_new = (mode != MODE_NORMAL && at_top) ? '0 : count_t'(cur.cnt + 1'b1);
        bottom  = (cnt_new == '0);
        ovf     = strobe && (pwm ? at_top : (cur.cnt == '1));
        conn_a  = connected(com_a, pwm, mode == MODE_PWM_CMPA);
        conn_b  = connected(com_b, pwm, 1'b0);

        nxt.pre      = running ? prescale_t'(cur.pre + 1'b1) : cur.pre;
        nxt.cnt      = strobe ? cnt_new : cur.cnt;
        nxt.pin_a    = strobe ? wave_next(cur.pin_a, com_a, pwm, conn_a,
                                          cur.cnt == cfg.cmp_a, bottom) : cur.pin_a;
        nxt.pin_b    = strobe ? wave_next(cur.pin_b, com_b, pwm, conn_b,
                                          cur.cnt == cfg.cmp_b, bottom) : cur.pin_b;
        nxt.last_pin = capture_pin;
        // latch the count held before this tick's strobe
        nxt.cap      = cap_ev ? cur.cnt : cur.cap;

        res.count_now     = nxt.cnt;
        res.wave_a        = conn_a & nxt.pin_a;
        res.wave_b        = conn_b & nxt.pin_b;
        res.overflow_irq  = ovf & cfg.irq_en[0];
        res.capture_irq   = cap_ev & cfg.irq_en[1];
        res.capture_value = nxt.cap;
    end

endmodule

// ===== rtl/core/timer16_pwm_capture.sv =====
// Top level of the 16-bit timer/counter with fast PWM and input capture.
//
//  channel   dir  handshake      payload
//  cap       in   valid/ready    capture_pin
//  res       out  valid/ready    count_now, wave_a, wave_b, overflow_irq,
//                                capture_irq, capture_value
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// One tick beat is taken per cycle when cap.ready is high; each result passes
// the input register, then the result register, with the combinational tick
// update between them. Timer state advances when a beat moves into the result
// register. rst_n clears all but the payload registers. A stalled result holds
// both stages; the input side keeps taking beats while the stage ahead drains.
module timer16_pwm_capture import t16pc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    t16pc_cap_if.sink             cap,
    t16pc_res_if.source           res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    s1_valid_reg;
    logic    s1_pin_reg;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    s1_go;

    assign s1_go     = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cap.ready = !s1_valid_reg || s1_go;

    t16pc_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .capture_pin (s1_pin_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            state_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WAVE_MODE:    cfg_reg.wave_mode    <= cfg_data[2:0];
                    REG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[2:0];
                    REG_COMPARE_A:    cfg_reg.cmp_a        <= count_t'(cfg_data);
                    REG_COMPARE_B:    cfg_reg.cmp_b        <= count_t'(cfg_data);
                    REG_TOP:          cfg_reg.top_reg      <= count_t'(cfg_data);
                    REG_OUTPUT_MODES: cfg_reg.output_modes <= cfg_data[3:0];
                    REG_CAP_RISING:   cfg_reg.cap_rising   <= cfg_data[0];
                    REG_IRQ_ENABLES:  cfg_reg.irq_en       <= cfg_data[1:0];
                    default:          cfg_reg              <= cfg_reg;
                endcase
            end

            if (cap.ready)
                s1_valid_reg <= cap.valid;

            if (s1_go)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (cap.valid && cap.ready)
            s1_pin_reg <= cap.capture_pin;
        if (s1_go)
            res_reg <= res_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.count_now     = res_reg.count_now;
    assign res.wave_a        = res_reg.wave_a;
    assign res.wave_b        = res_reg.wave_b;
    assign res.overflow_irq  = res_reg.overflow_irq;
    assign res.capture_irq   = res_reg.capture_irq;
    assign res.capture_value = res_reg.capture_value;

    a_go_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> res_valid_reg)
        else $error("tick beat advanced but no result was registered");

    a_stopped_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && cfg_reg.clock_select == CS_STOP)
            |=> (res_reg.count_now == $past(state_reg.cnt)))
        else $error("counter moved while the timer clock was stopped");

    a_no_capture_regtop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (cfg_reg.wave_mode == MODE_CTC_CAP ||
                           cfg_reg.wave_mode == MODE_PWM_CAP))
            |-> !res_reg.capture_irq)
        else $error("capture pulse in a capture-register-top mode");

    a_capture_latches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && res_next.capture_irq)
            |=> (res_reg.capture_value == $past(state_reg.cnt)))
        else $error("capture pulse without the pre-strobe count latched");

endmodule
